### rtl/atl_pkg.sv
// Shared types and constants for the arithmetic token lexer.
package atl_pkg;

  localparam int unsigned MaxFractionDigits = 9;
  localparam int unsigned FifoDepth         = 4;

  typedef enum logic [3:0] {
    TokPlus     = 4'd0,
    TokMinus    = 4'd1,
    TokAsterisk = 4'd2,
    TokSlash    = 4'd3,
    TokPower    = 4'd4,
    TokInteger  = 4'd5,
    TokDecimal  = 4'd6,
    TokEnd      = 4'd7,
    TokInvalid  = 4'd8
  } token_kind_e;

  typedef enum logic [1:0] {
    ModeIdle  = 2'd0,
    ModeStar  = 2'd1,
    ModeWhole = 2'd2,
    ModeFrac  = 2'd3
  } lex_mode_e;

  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharStar  = 8'h2A;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharPoint = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;

  localparam logic [30:0] WholeMax = 31'h7FFF_FFFF;

  typedef struct packed {
    token_kind_e kind;
    logic [30:0] integer_part;
    logic [29:0] fraction_digits;
    logic [3:0]  fraction_length;
    logic        saturated;
    logic        last_of_run;
  } token_t;

endpackage

### rtl/arithmetic_token_lexer.sv
// Arithmetic expression lexer: one character per transaction in, tokens out.
//
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   in_byte_i, end_of_input_i
// out      output     out_valid_o / out_ready_i token_kind_o, integer_part_o,
//                                               fraction_digits_o, fraction_length_o,
//                                               saturated_o, last_of_run_o
//
// Each character is decoded in the cycle it is accepted and its tokens (zero, one
// or two) are written into a four-entry token queue; they can be taken in the next cycle.
// One character is accepted per cycle while the queue has two free entries, so the
// rate is one character per cycle and is bounded by the one-token-per-cycle output port.
// Reset clears the lexer mode, the number accumulators and the token queue.
// A stalled output fills the queue and then holds in_ready_o low until entries drain.
module arithmetic_token_lexer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  token_kind_o,
  output logic [30:0] integer_part_o,
  output logic [29:0] fraction_digits_o,
  output logic [3:0]  fraction_length_o,
  output logic        saturated_o,
  output logic        last_of_run_o
);

  localparam int unsigned PtrW = $clog2(atl_pkg::FifoDepth);
  localparam int unsigned CntW = $clog2(atl_pkg::FifoDepth + 1);

  atl_pkg::lex_mode_e mode_q, mode_d;
  logic [30:0] whole_q, whole_d;
  logic [29:0] frac_q, frac_d;
  logic [3:0]  fcnt_q, fcnt_d;
  logic        ovf_q, ovf_d;

  atl_pkg::token_t fifo_q [atl_pkg::FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  logic in_fire, out_fire;
  logic eoi, is_digit, is_space;
  logic [7:0] digit_raw;
  logic [3:0] digit;
  logic [34:0] whole_mac;
  logic        whole_sat;
  logic [29:0] frac_mac;

  logic                   idle_emit, idle_start;
  atl_pkg::token_kind_e   idle_kind;
  atl_pkg::lex_mode_e     idle_mode;

  logic                 pre_emit, pre_num, run_idle;
  atl_pkg::token_kind_e pre_kind;

  atl_pkg::token_t tok0, tok1;
  logic [1:0]      push_n;

  assign in_ready_o = count_q <= CntW'(atl_pkg::FifoDepth - 2);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_valid_o = count_q != '0;
  assign out_fire   = out_valid_o && out_ready_i;

  assign eoi       = end_of_input_i;
  assign is_digit  = (in_byte_i >= atl_pkg::CharZero) && (in_byte_i <= atl_pkg::CharNine);
  assign is_space  = (in_byte_i == atl_pkg::CharSpace) ||
                     ((in_byte_i >= atl_pkg::CharTab) && (in_byte_i <= atl_pkg::CharCr));
  assign digit_raw = in_byte_i - atl_pkg::CharZero;
  assign digit     = digit_raw[3:0];

  assign whole_mac = {1'b0, whole_q, 3'b000} + {3'b000, whole_q, 1'b0} + {31'd0, digit};
  assign whole_sat = whole_mac > {4'd0, atl_pkg::WholeMax};
  assign frac_mac  = {frac_q[26:0], 3'b000} + {frac_q[28:0], 1'b0} + {26'd0, digit};

  // Decode of a character seen with no token pending.
  always_comb begin
    idle_emit  = 1'b0;
    idle_start = 1'b0;
    idle_kind  = atl_pkg::TokInvalid;
    idle_mode  = atl_pkg::ModeIdle;
    priority if (eoi) begin
      idle_emit = 1'b1;
      idle_kind = atl_pkg::TokEnd;
    end else if (is_space) begin
      idle_emit = 1'b0;
    end else if (in_byte_i == atl_pkg::CharPlus) begin
      idle_emit = 1'b1;
      idle_kind = atl_pkg::TokPlus;
    end else if (in_byte_i == atl_pkg::CharMinus) begin
      idle_emit = 1'b1;
      idle_kind = atl_pkg::TokMinus;
    end else if (in_byte_i == atl_pkg::CharSlash) begin
      idle_emit = 1'b1;
      idle_kind = atl_pkg::TokSlash;
    end else if (in_byte_i == atl_pkg::CharStar) begin
      idle_mode = atl_pkg::ModeStar;
    end else if (is_digit) begin
      idle_start = 1'b1;
      idle_mode  = atl_pkg::ModeWhole;
    end else begin
      idle_emit = 1'b1;
      idle_kind = atl_pkg::TokInvalid;
    end
  end

  // Next lexer state and the pending token that a character closes.
  always_comb begin
    mode_d   = mode_q;
    whole_d  = whole_q;
    frac_d   = frac_q;
    fcnt_d   = fcnt_q;
    ovf_d    = ovf_q;
    pre_emit = 1'b0;
    pre_num  = 1'b0;
    pre_kind = atl_pkg::TokInvalid;
    run_idle = 1'b0;
    if (in_fire) begin
      unique case (mode_q)
        atl_pkg::ModeStar: begin
          if (!eoi && (in_byte_i == atl_pkg::CharStar)) begin
            pre_emit = 1'b1;
            pre_kind = atl_pkg::TokPower;
            mode_d   = atl_pkg::ModeIdle;
          end else begin
            pre_emit = 1'b1;
            pre_kind = atl_pkg::TokAsterisk;
            run_idle = 1'b1;
          end
        end
        atl_pkg::ModeWhole: begin
          if (!eoi && is_digit) begin
            whole_d = whole_sat ? atl_pkg::WholeMax : whole_mac[30:0];
            ovf_d   = ovf_q | whole_sat;
          end else if (!eoi && (in_byte_i == atl_pkg::CharPoint)) begin
            mode_d = atl_pkg::ModeFrac;
          end else begin
            pre_emit = 1'b1;
            pre_num  = 1'b1;
            pre_kind = atl_pkg::TokInteger;
            run_idle = 1'b1;
          end
        end
        atl_pkg::ModeFrac: begin
          if (!eoi && is_digit) begin
            if (fcnt_q < 4'(atl_pkg::MaxFractionDigits)) begin
              frac_d = frac_mac;
              fcnt_d = fcnt_q + 4'd1;
            end
          end else begin
            pre_emit = 1'b1;
            pre_num  = 1'b1;
            pre_kind = atl_pkg::TokDecimal;
            run_idle = 1'b1;
          end
        end
        default: begin
          run_idle = 1'b1;
        end
      endcase
      if (run_idle) begin
        mode_d = idle_mode;
        if (idle_start) begin
          whole_d = {27'd0, digit};
          frac_d  = '0;
          fcnt_d  = '0;
          ovf_d   = 1'b0;
        end
      end
    end
  end

  // Tokens produced by the accepted character.
  always_comb begin
    atl_pkg::token_t pre_tok, idle_tok;
    pre_tok.kind            = pre_kind;
    pre_tok.integer_part    = pre_num ? whole_q : '0;
    pre_tok.fraction_digits = (pre_num && (pre_kind == atl_pkg::TokDecimal)) ? frac_q : '0;
    pre_tok.fraction_length = (pre_num && (pre_kind == atl_pkg::TokDecimal)) ? fcnt_q : '0;
    pre_tok.saturated       = pre_num ? ovf_q : 1'b0;
    pre_tok.last_of_run     = 1'b1;
    idle_tok.kind            = idle_kind;
    idle_tok.integer_part    = '0;
    idle_tok.fraction_digits = '0;
    idle_tok.fraction_length = '0;
    idle_tok.saturated       = 1'b0;
    idle_tok.last_of_run     = 1'b1;
    tok0   = idle_tok;
    tok1   = idle_tok;
    push_n = 2'd0;
    if (pre_emit && run_idle && idle_emit) begin
      tok0             = pre_tok;
      tok0.last_of_run = 1'b0;
      push_n           = 2'd2;
    end else if (pre_emit) begin
      tok0   = pre_tok;
      push_n = 2'd1;
    end else if (run_idle && idle_emit) begin
      push_n = 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= atl_pkg::ModeIdle;
      whole_q  <= '0;
      frac_q   <= '0;
      fcnt_q   <= '0;
      ovf_q    <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      mode_q   <= mode_d;
      whole_q  <= whole_d;
      frac_q   <= frac_d;
      fcnt_q   <= fcnt_d;
      ovf_q    <= ovf_d;
      wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      rd_ptr_q <= rd_ptr_q + PtrW'(out_fire);
      count_q  <= count_q + CntW'(push_n) - CntW'(out_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= tok0;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_q + PtrW'(1)] <= tok1;
    end
  end

  assign token_kind_o      = fifo_q[rd_ptr_q].kind;
  assign integer_part_o    = fifo_q[rd_ptr_q].integer_part;
  assign fraction_digits_o = fifo_q[rd_ptr_q].fraction_digits;
  assign fraction_length_o = fifo_q[rd_ptr_q].fraction_length;
  assign saturated_o       = fifo_q[rd_ptr_q].saturated;
  assign last_of_run_o     = fifo_q[rd_ptr_q].last_of_run;

  // The token queue never holds more entries than it has.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(atl_pkg::FifoDepth))
    else $error("Token queue count exceeds its depth.");

  // End of input always leaves the lexer idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && end_of_input_i) |=> (mode_q == atl_pkg::ModeIdle))
    else $error("Lexer not idle after end of input.");

  // A pending star is always resolved by the next character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (mode_q == atl_pkg::ModeStar)) |=> (mode_q != atl_pkg::ModeStar))
    else $error("Pending star survived a transaction.");

  // The kept fraction never grows past its digit limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= 4'(atl_pkg::MaxFractionDigits))
    else $error("Fraction digit count exceeds its limit.");

endmodule
